// ----- hdl/ptsb_pkg.sv -----
// ----------------------------------------------------------------------------
// ptsb_pkg
// Shared types, operation codes and sizes of the periodic timer slot bank.
// ----------------------------------------------------------------------------
package ptsb_pkg;

	localparam int TIMER_SLOTS_DEF = 8;
	localparam int SLOT_W          = 3;
	localparam int KIND_W          = 4;
	localparam int CNT_W           = 16;
	localparam int MAX_RESULTS     = 8;

	localparam logic [KIND_W-1:0] KIND_TICK    = 4'd0;
	localparam logic [KIND_W-1:0] KIND_CREATE  = 4'd1;
	localparam logic [KIND_W-1:0] KIND_RUN     = 4'd2;
	localparam logic [KIND_W-1:0] KIND_STOP    = 4'd3;
	localparam logic [KIND_W-1:0] KIND_RESTART = 4'd4;
	localparam logic [KIND_W-1:0] KIND_RESET   = 4'd5;
	localparam logic [KIND_W-1:0] KIND_CHANGE  = 4'd6;
	localparam logic [KIND_W-1:0] KIND_DELETE  = 4'd7;
	localparam logic [KIND_W-1:0] KIND_STATUS  = 4'd8;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  period;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot_out;
		logic              fired;
		logic              ok;
		logic              running;
		logic              last;
	} rsp_t;

endpackage

// ----- hdl/ptsb_stream_if.sv -----
// ----------------------------------------------------------------------------
// ptsb_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ptsb_stream_if #(
	parameter type data_t = logic
) ();

	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ----- hdl/ptsb_ram.sv -----
// ----------------------------------------------------------------------------
// ptsb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ptsb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/periodic_timer_slot_bank_top.sv -----
// ----------------------------------------------------------------------------
// periodic_timer_slot_bank_top
// Bank of periodic timer slots. Every command other than tick gives one
// beat. A tick walks the count and period memories one slot per cycle,
// reading the next slot while writing back the current one, and stalls
// while a new fire must push out a held one the response side is not
// ready for. It gives one beat per fired slot (at most eight) or a single
// no-fire beat. Allocation and running flags live in flip-flops cleared by
// reset; count and period entries are only used for allocated slots, which
// create always writes, so no clearing pass runs after reset.
// ----------------------------------------------------------------------------
module periodic_timer_slot_bank_top #(
	parameter int TIMER_SLOTS = ptsb_pkg::TIMER_SLOTS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ptsb_stream_if.sink   cmd,
	ptsb_stream_if.source rsp
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int N_W   = $clog2(ptsb_pkg::MAX_RESULTS + 1);
	localparam int CNT_W = ptsb_pkg::CNT_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]             state_q;
	logic [IDX_W-1:0]       cur_q;
	logic [N_W-1:0]         n_q;
	logic                   pend_v_q;
	logic [IDX_W-1:0]       pend_slot_q;
	logic [TIMER_SLOTS-1:0] alloc_q;
	logic [TIMER_SLOTS-1:0] run_q;
	logic                   out_valid_q;
	ptsb_pkg::rsp_t         out_q;

	logic                   out_free;
	logic                   accept;
	logic                   is_tick;
	logic                   is_create;
	logic                   op_accept;
	logic                   slot_ok;
	logic [IDX_W-1:0]       slot_idx;
	logic [IDX_W-1:0]       free_idx;
	logic                   free_found;
	logic                   run_new;
	ptsb_pkg::rsp_t         op_rsp;

	logic [CNT_W-1:0]       cnt_rd;
	logic [CNT_W-1:0]       per_rd;
	logic [CNT_W-1:0]       cnt_inc;
	logic                   act;
	logic                   fire;
	logic                   report;
	logic                   advance;
	logic                   cur_last;

	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic [IDX_W-1:0]       wr_addr;
	logic                   cnt_we;
	logic [CNT_W-1:0]       cnt_wdata;
	logic                   per_we;

	logic                   out_load;
	ptsb_pkg::rsp_t         out_next;
	logic                   pend_load;

	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = cmd.valid && cmd.ready;
	assign is_tick   = (cmd.data.kind == ptsb_pkg::KIND_TICK);
	assign is_create = (cmd.data.kind == ptsb_pkg::KIND_CREATE);
	assign op_accept = accept && !is_tick;
	assign slot_ok   = (int'(cmd.data.slot) < TIMER_SLOTS);
	assign slot_idx  = IDX_W'(cmd.data.slot);

	// lowest free slot
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!alloc_q[i]) begin
				free_idx   = IDX_W'(i);
				free_found = 1'b1;
			end
		end
	end

	always_comb begin
		unique case (cmd.data.kind) inside
			ptsb_pkg::KIND_RUN, ptsb_pkg::KIND_RESTART: run_new = 1'b1;
			ptsb_pkg::KIND_STOP, ptsb_pkg::KIND_RESET,
			ptsb_pkg::KIND_DELETE:                      run_new = 1'b0;
			default:                                    run_new = run_q[slot_idx];
		endcase
	end

	always_comb begin
		op_rsp.fired = 1'b0;
		op_rsp.last  = 1'b1;
		if (is_create) begin
			op_rsp.slot_out = free_found ? ptsb_pkg::SLOT_W'(free_idx) : '0;
			op_rsp.ok       = free_found;
			op_rsp.running  = 1'b0;
		end else begin
			op_rsp.slot_out = cmd.data.slot;
			op_rsp.ok       = 1'b1;
			op_rsp.running  = slot_ok ? run_new : 1'b0;
		end
	end

	// walk stage: memory data belongs to slot cur_q
	assign act      = alloc_q[cur_q] && run_q[cur_q];
	assign cnt_inc  = cnt_rd + 16'd1;
	assign fire     = act && (cnt_inc >= per_rd);
	assign report   = fire && (n_q < N_W'(ptsb_pkg::MAX_RESULTS));
	// a new fire pushes the held one out, so it needs room downstream
	assign advance  = !(report && pend_v_q) || out_free;
	assign cur_last = (cur_q == IDX_W'(TIMER_SLOTS - 1));

	assign rd_en   = ((state_q == ST_IDLE) && accept && is_tick)
	              || ((state_q == ST_WALK) && advance && !cur_last);
	assign rd_addr = (state_q == ST_IDLE) ? '0 : IDX_W'(cur_q + 1'b1);

	always_comb begin
		if (state_q == ST_WALK) begin
			wr_addr = cur_q;
		end else if (is_create) begin
			wr_addr = free_idx;
		end else begin
			wr_addr = slot_idx;
		end
	end

	assign cnt_we = (op_accept && ((is_create && free_found)
	                 || (slot_ok && ((cmd.data.kind == ptsb_pkg::KIND_RESTART)
	                              || (cmd.data.kind == ptsb_pkg::KIND_RESET)))))
	             || ((state_q == ST_WALK) && advance && act);
	assign cnt_wdata = ((state_q == ST_WALK) && !fire) ? cnt_inc : '0;
	assign per_we = op_accept && ((is_create && free_found)
	                || (slot_ok && (cmd.data.kind == ptsb_pkg::KIND_CHANGE)));

	ptsb_ram #(
		.WIDTH (CNT_W),
		.DEPTH (TIMER_SLOTS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (wr_addr),
		.wdata (cnt_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (cnt_rd)
	);

	ptsb_ram #(
		.WIDTH (CNT_W),
		.DEPTH (TIMER_SLOTS)
	) u_per_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (wr_addr),
		.wdata (cmd.data.period),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (per_rd)
	);

	always_comb begin
		out_load  = 1'b0;
		out_next  = op_rsp;
		pend_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				out_load = op_accept;
			end
			ST_WALK: begin
				pend_load = advance && report;
				out_load  = advance && report && pend_v_q;
				out_next.slot_out = ptsb_pkg::SLOT_W'(pend_slot_q);
				out_next.fired    = 1'b1;
				out_next.ok       = 1'b1;
				out_next.running  = 1'b1;
				out_next.last     = 1'b0;
			end
			ST_FLUSH: begin
				out_load = out_free;
				out_next.slot_out = pend_v_q ? ptsb_pkg::SLOT_W'(pend_slot_q) : '0;
				out_next.fired    = pend_v_q;
				out_next.ok       = 1'b1;
				out_next.running  = pend_v_q;
				out_next.last     = 1'b1;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			n_q         <= '0;
			pend_v_q    <= 1'b0;
			alloc_q     <= '0;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_tick) begin
						state_q  <= ST_WALK;
						cur_q    <= '0;
						n_q      <= '0;
						pend_v_q <= 1'b0;
					end else if (op_accept) begin
						if (is_create) begin
							if (free_found) begin
								alloc_q[free_idx] <= 1'b1;
								run_q[free_idx]   <= 1'b0;
							end
						end else if (slot_ok) begin
							run_q[slot_idx] <= run_new;
							if (cmd.data.kind == ptsb_pkg::KIND_DELETE) begin
								alloc_q[slot_idx] <= 1'b0;
							end
						end
					end
				end
				ST_WALK: begin
					if (advance) begin
						if (report) begin
							pend_v_q <= 1'b1;
							n_q      <= n_q + 1'b1;
						end
						if (cur_last) begin
							state_q <= ST_FLUSH;
						end else begin
							cur_q <= cur_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
		if (pend_load) begin
			pend_slot_q <= cur_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule
